// ===== design/fcct_pkg.sv =====
`default_nettype none

package fcct_pkg;

    typedef enum logic [2:0] {
        REQ_CONTROL = 3'd0,
        REQ_TCONST  = 3'd1,
        REQ_TRIGGER = 3'd2,
        REQ_TICK    = 3'd3,
        REQ_ACK     = 3'd4
    } req_type_t;

    // control word bits
    localparam logic [7:0] CW_IRQ_EN  = 8'h80;
    localparam logic [7:0] CW_COUNTER = 8'h40;
    localparam logic [7:0] CW_PRE256  = 8'h20;
    localparam logic [7:0] CW_RISING  = 8'h10;
    localparam logic [7:0] CW_TC_NEXT = 8'h04;
    localparam logic [7:0] CW_RESET   = 8'h02;

    localparam logic [8:0] PRESCALE_SHORT = 9'd16;
    localparam logic [8:0] PRESCALE_LONG  = 9'd256;

    typedef struct packed {
        logic      fire;       // item is processed this cycle
        req_type_t req;
        logic      sel;        // item addresses this channel
        logic [7:0] data;
        logic      level;
        logic      ack_clear;  // this channel is served by the acknowledge
    } chan_cmd_t;

    typedef struct packed {
        logic irq_req;         // enabled and pending now
        logic irq_req_next;    // enabled and pending after this item
        logic zero;            // count reached zero on this item
    } chan_stat_t;

    // a time constant of zero stands for 256
    function automatic logic [8:0] full_value(input logic [7:0] v);
        full_value = (v == 8'd0) ? 9'd256 : {1'b0, v};
    endfunction

endpackage

`default_nettype wire

// ===== design/four_channel_counter_timer.sv =====
// Four counter/timer channels driven by a stream of request beats.
// Slave side (s_*): one request per beat. s_tuser carries the request kind,
// s_tdata the channel, the control word or time constant, and the trigger level.
// Master side (m_*): exactly one result beat per request, in request order,
// carrying the acknowledge outcome, the vector, the interrupt line and the
// mask of channels that reached zero.
// cfg_*: writes the 32-bit vector bank (byte i for channel i); always ready.
// Write it only while no request is in flight.
// Pipeline: a request accepted into the input register is worked when it
// advances, which loads its result onto m_tdata (input register, then result
// register). One request per cycle is sustained while the receiver takes
// results; all channels update in parallel.
// When the result register is held by a stalled receiver, one further beat
// is taken into the input register and then s_tready drops until the result
// is taken. Reset clears all channel state, the vector bank and both stages.
`default_nettype none

module four_channel_counter_timer
    import fcct_pkg::*;
#(
    parameter int NUM_CHANNELS = 4
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // channel[1:0], data[9:2], trigger_level[10], zero pad
    input  wire logic [2:0]  s_tuser,   // req_type[2:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // ack_valid[0], ack_channel[2:1], read_vector[10:3],
                                        // irq_pending[11], zero_mask[15:12]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data
);

    localparam int MAX_CHANNELS = 4;

    logic        in_valid_reg;
    logic [2:0]  in_req_reg;
    logic [1:0]  in_channel_reg;
    logic [7:0]  in_data_reg;
    logic        in_level_reg;
    logic [31:0] vector_bank_reg;
    logic        m_tvalid_reg;
    logic [15:0] m_tdata_reg;

    logic        adv;
    req_type_t   req;
    logic        ack_found;
    logic [1:0]  ack_ch;
    logic [7:0]  ack_vec;
    logic [MAX_CHANNELS-1:0] serve;
    logic [MAX_CHANNELS-1:0] zero_mask;
    logic        irq_next;
    chan_stat_t  stat [MAX_CHANNELS];

    assign adv       = in_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready  = !in_valid_reg || adv;
    assign cfg_ready = 1'b1;
    assign req       = req_type_t'(in_req_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_req_reg     <= s_tuser;
            in_channel_reg <= s_tdata[1:0];
            in_data_reg    <= s_tdata[9:2];
            in_level_reg   <= s_tdata[10];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vector_bank_reg <= 32'd0;
        else if (cfg_valid && cfg_ready)
            vector_bank_reg <= cfg_data;
    end

    // lowest enabled pending channel wins the acknowledge
    always_comb
    begin
        ack_found = 1'b0;
        ack_ch    = 2'd0;
        ack_vec   = 8'd0;
        serve     = '0;
        for (int c = 0; c < MAX_CHANNELS; c++)
        begin
            if (!ack_found && stat[c].irq_req)
            begin
                ack_found = 1'b1;
                ack_ch    = 2'(c);
                ack_vec   = vector_bank_reg[8*c +: 8];
                serve[c]  = 1'b1;
            end
        end
        if (req != REQ_ACK)
        begin
            ack_found = 1'b0;
            ack_ch    = 2'd0;
            ack_vec   = 8'd0;
            serve     = '0;
        end
    end

    for (genvar gi = 0; gi < MAX_CHANNELS; gi++)
    begin : g_chan
        if (gi < NUM_CHANNELS)
        begin : g_used
            chan_cmd_t cmd;
            assign cmd.fire      = adv;
            assign cmd.req       = req;
            assign cmd.sel       = (in_channel_reg == 2'(gi));
            assign cmd.data      = in_data_reg;
            assign cmd.level     = in_level_reg;
            assign cmd.ack_clear = serve[gi];

            fcct_channel u_channel (
                .clk   (clk),
                .rst_n (rst_n),
                .cmd   (cmd),
                .stat  (stat[gi])
            );
        end
        else
        begin : g_unused
            assign stat[gi] = '0;
        end
    end

    always_comb
    begin
        irq_next = 1'b0;
        for (int c = 0; c < MAX_CHANNELS; c++)
        begin
            zero_mask[c] = stat[c].zero;
            irq_next     = irq_next | stat[c].irq_req_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (adv)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            m_tdata_reg <= {zero_mask, irq_next, ack_vec, ack_ch, ack_found};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_serve_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(serve))
        else $error("acknowledge serves more than one channel");

    a_ack_reported: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && req == REQ_ACK && (stat[0].irq_req || stat[1].irq_req ||
         stat[2].irq_req || stat[3].irq_req)) |=> (m_tvalid && m_tdata[0]))
        else $error("pending interrupt not acknowledged");

    a_ack_channel_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[0]) |-> ({1'b0, m_tdata[2:1]} < 3'(NUM_CHANNELS)))
        else $error("acknowledge names a channel that does not exist");

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && m_tvalid_reg && !m_tready))
        else $error("input stalled without a held result");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> m_tvalid)
        else $error("processed beat produced no result");

endmodule

`default_nettype wire

// ===== design/fcct_channel.sv =====
`default_nettype none

module fcct_channel
    import fcct_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire chan_cmd_t  cmd,
    output chan_stat_t      stat
);

    logic       irq_enable_reg,   irq_enable_next;
    logic       counter_mode_reg, counter_mode_next;
    logic       prescale_256_reg, prescale_256_next;
    logic       rising_edge_reg,  rising_edge_next;
    logic       running_reg,      running_next;
    logic       pending_reg,      pending_next;
    logic [8:0] down_count_reg,   down_count_next;
    logic [7:0] reload_value_reg, reload_value_next;
    logic [7:0] prescale_count_reg, prescale_count_next;
    logic       last_level_reg,   last_level_next;

    logic       do_advance;
    logic       edge_seen;
    logic [8:0] pre_limit;
    logic [8:0] pre_inc;
    logic [8:0] dec_count;
    logic       zero_hit;

    always_comb
    begin
        irq_enable_next     = irq_enable_reg;
        counter_mode_next   = counter_mode_reg;
        prescale_256_next   = prescale_256_reg;
        rising_edge_next    = rising_edge_reg;
        running_next        = running_reg;
        pending_next        = pending_reg;
        down_count_next     = down_count_reg;
        reload_value_next   = reload_value_reg;
        prescale_count_next = prescale_count_reg;
        last_level_next     = last_level_reg;
        do_advance          = 1'b0;

        edge_seen = rising_edge_reg ? (!last_level_reg && cmd.level)
                                    : (last_level_reg && !cmd.level);
        pre_limit = prescale_256_reg ? PRESCALE_LONG : PRESCALE_SHORT;
        pre_inc   = {1'b0, prescale_count_reg} + 9'd1;

        if (cmd.fire)
        begin
            case (cmd.req)
                REQ_CONTROL:
                begin
                    if (cmd.sel)
                    begin
                        irq_enable_next   = |(cmd.data & CW_IRQ_EN);
                        counter_mode_next = |(cmd.data & CW_COUNTER);
                        prescale_256_next = |(cmd.data & CW_PRE256);
                        rising_edge_next  = |(cmd.data & CW_RISING);
                        if (|(cmd.data & CW_RESET))
                        begin
                            down_count_next = 9'd0;
                            running_next    = 1'b0;
                            pending_next    = 1'b0;
                        end
                        if (|(cmd.data & CW_TC_NEXT))
                            running_next = 1'b0;
                    end
                end
                REQ_TCONST:
                begin
                    if (cmd.sel)
                    begin
                        reload_value_next = cmd.data;
                        down_count_next   = full_value(cmd.data);
                        running_next      = 1'b1;
                        pending_next      = 1'b0;
                    end
                end
                REQ_TRIGGER:
                begin
                    if (cmd.sel && counter_mode_reg)
                    begin
                        do_advance      = edge_seen && running_reg;
                        last_level_next = cmd.level;
                    end
                end
                REQ_TICK:
                begin
                    if (!counter_mode_reg && running_reg)
                    begin
                        if (pre_inc < pre_limit)
                            prescale_count_next = pre_inc[7:0];
                        else
                        begin
                            prescale_count_next = 8'd0;
                            do_advance          = 1'b1;
                        end
                    end
                end
                REQ_ACK:
                begin
                    if (cmd.ack_clear)
                        pending_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end

        // a count already at zero stays there and so reloads at once
        dec_count = (down_count_reg != 9'd0) ? down_count_reg - 9'd1 : 9'd0;
        zero_hit  = do_advance && (dec_count == 9'd0);
        if (do_advance)
        begin
            if (zero_hit)
            begin
                down_count_next = full_value(reload_value_reg);
                if (irq_enable_reg)
                    pending_next = 1'b1;
            end
            else
                down_count_next = dec_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            irq_enable_reg     <= 1'b0;
            counter_mode_reg   <= 1'b0;
            prescale_256_reg   <= 1'b0;
            rising_edge_reg    <= 1'b0;
            running_reg        <= 1'b0;
            pending_reg        <= 1'b0;
            down_count_reg     <= 9'd0;
            reload_value_reg   <= 8'd0;
            prescale_count_reg <= 8'd0;
            last_level_reg     <= 1'b0;
        end
        else
        begin
            irq_enable_reg     <= irq_enable_next;
            counter_mode_reg   <= counter_mode_next;
            prescale_256_reg   <= prescale_256_next;
            rising_edge_reg    <= rising_edge_next;
            running_reg        <= running_next;
            pending_reg        <= pending_next;
            down_count_reg     <= down_count_next;
            reload_value_reg   <= reload_value_next;
            prescale_count_reg <= prescale_count_next;
            last_level_reg     <= last_level_next;
        end
    end

    assign stat.irq_req      = irq_enable_reg && pending_reg;
    assign stat.irq_req_next = irq_enable_next && pending_next;
    assign stat.zero         = zero_hit;

endmodule

`default_nettype wire

// ===== tb/four_channel_counter_timer_test.sv =====
module four_channel_counter_timer_test;

    timeunit 1ns;
    timeprecision 1ps;

    import fcct_pkg::*;

    localparam int NUM_CHANNELS    = 4;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 3000;

    // request kinds the block does not decode
    localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;
    localparam logic [2:0] REQ_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [2:0] kind;
        logic [1:0] chan;
        logic [7:0] data;
        logic       level;
    } request_t;

    // declared from the top bit down so that it lines up with m_tdata
    typedef struct packed {
        logic [3:0] zero_mask;
        logic       irq;
        logic [7:0] vector;
        logic [1:0] ack_chan;
        logic       ack_valid;
    } result_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    wire logic   s_tready;
    logic [15:0] s_tdata   = '0;    // channel[1:0], data[9:2], trigger_level[10], zero pad
    logic [2:0]  s_tuser   = '0;    // req_type[2:0]
    wire logic   m_tvalid;
    logic        m_tready  = 1'b0;
    wire logic [15:0] m_tdata;      // ack_valid[0], ack_channel[2:1], read_vector[10:3],
                                    // irq_pending[11], zero_mask[15:12]
    logic        cfg_valid = 1'b0;
    wire logic   cfg_ready;
    logic [31:0] cfg_data  = '0;

    // channel model
    logic        ch_irq_en     [NUM_CHANNELS];
    logic        ch_counter    [NUM_CHANNELS];
    logic        ch_pre256     [NUM_CHANNELS];
    logic        ch_rising     [NUM_CHANNELS];
    logic        ch_running    [NUM_CHANNELS];
    logic        ch_pending    [NUM_CHANNELS];
    logic        ch_last_level [NUM_CHANNELS];
    logic [8:0]  ch_count      [NUM_CHANNELS];
    logic [7:0]  ch_reload     [NUM_CHANNELS];
    logic [7:0]  ch_prescale   [NUM_CHANNELS];
    logic [31:0] vector_model;

    result_t expected_results [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    logic stall_start = 1'b0;

    int errors        = 0;
    int requests_sent = 0;
    int beats_checked = 0;
    int zero_beats    = 0;
    int acks_served   = 0;

    four_channel_counter_timer #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            ch_irq_en[c]     = 1'b0;
            ch_counter[c]    = 1'b0;
            ch_pre256[c]     = 1'b0;
            ch_rising[c]     = 1'b0;
            ch_running[c]    = 1'b0;
            ch_pending[c]    = 1'b0;
            ch_last_level[c] = 1'b0;
            ch_count[c]      = '0;
            ch_reload[c]     = '0;
            ch_prescale[c]   = '0;
        end
        vector_model = '0;
    end

    // time constant 0 stands for 256
    function automatic logic [8:0] count_from(input logic [7:0] v);
        return (v == 8'd0) ? 9'd256 : {1'b0, v};
    endfunction

    // one step of the down counter; high when it wraps through zero
    function automatic logic advance_channel(input int c);
        if (ch_count[c] != 9'd0)
            ch_count[c] = ch_count[c] - 9'd1;
        if (ch_count[c] != 9'd0)
            return 1'b0;
        ch_count[c] = count_from(ch_reload[c]);
        if (ch_irq_en[c])
            ch_pending[c] = 1'b1;
        return 1'b1;
    endfunction

    function automatic result_t predict_result(input request_t r);
        result_t    res;
        logic       edge_seen;
        logic [8:0] limit_val;
        logic [8:0] next_pre;
        res = '0;
        case (r.kind)
            REQ_CONTROL:
            begin
                ch_irq_en[r.chan]  = (r.data & CW_IRQ_EN) != 8'd0;
                ch_counter[r.chan] = (r.data & CW_COUNTER) != 8'd0;
                ch_pre256[r.chan]  = (r.data & CW_PRE256) != 8'd0;
                ch_rising[r.chan]  = (r.data & CW_RISING) != 8'd0;
                if ((r.data & CW_RESET) != 8'd0)
                begin
                    ch_count[r.chan]   = '0;
                    ch_running[r.chan] = 1'b0;
                    ch_pending[r.chan] = 1'b0;
                end
                if ((r.data & CW_TC_NEXT) != 8'd0)
                    ch_running[r.chan] = 1'b0;
            end
            REQ_TCONST:
            begin
                ch_reload[r.chan]  = r.data;
                ch_count[r.chan]   = count_from(r.data);
                ch_running[r.chan] = 1'b1;
                ch_pending[r.chan] = 1'b0;
            end
            REQ_TRIGGER:
            begin
                // timer channels ignore the pin altogether
                if (ch_counter[r.chan])
                begin
                    edge_seen = ch_rising[r.chan] ? (!ch_last_level[r.chan] && r.level)
                                                  : (ch_last_level[r.chan] && !r.level);
                    if (edge_seen && ch_running[r.chan] && advance_channel(int'(r.chan)))
                        res.zero_mask[r.chan] = 1'b1;
                    ch_last_level[r.chan] = r.level;
                end
            end
            REQ_TICK:
            begin
                for (int c = 0; c < NUM_CHANNELS; c++)
                begin
                    if (ch_counter[c] || !ch_running[c])
                        continue;
                    limit_val = ch_pre256[c] ? PRESCALE_LONG : PRESCALE_SHORT;
                    next_pre  = {1'b0, ch_prescale[c]} + 9'd1;
                    if (next_pre < limit_val)
                    begin
                        ch_prescale[c] = next_pre[7:0];
                        continue;
                    end
                    ch_prescale[c] = '0;
                    if (advance_channel(c))
                        res.zero_mask[c] = 1'b1;
                end
            end
            REQ_ACK:
            begin
                for (int c = 0; c < NUM_CHANNELS; c++)
                begin
                    if (!res.ack_valid && ch_irq_en[c] && ch_pending[c])
                    begin
                        ch_pending[c] = 1'b0;
                        res.ack_valid = 1'b1;
                        res.ack_chan  = 2'(c);
                        res.vector    = vector_model[8*c +: 8];
                    end
                end
            end
            default:
            begin
            end
        endcase
        for (int c = 0; c < NUM_CHANNELS; c++)
            if (ch_irq_en[c] && ch_pending[c])
                res.irq = 1'b1;
        return res;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin : beat_monitor
        result_t  got;
        result_t  want;
        request_t req;
        if (m_tvalid && m_tready)
        begin
            got = result_t'(m_tdata);
            if (expected_results.size() == 0)
            begin
                $display("%0t: result beat expected none, got %0h", $time, m_tdata);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("ack_valid", 32'(want.ack_valid), 32'(got.ack_valid));
                check_field("ack_channel", 32'(want.ack_chan), 32'(got.ack_chan));
                check_field("read_vector", 32'(want.vector), 32'(got.vector));
                check_field("irq_pending", 32'(want.irq), 32'(got.irq));
                check_field("zero_mask", 32'(want.zero_mask), 32'(got.zero_mask));
                beats_checked++;
                if (want.zero_mask != 4'd0)
                    zero_beats++;
                if (want.ack_valid)
                    acks_served++;
            end
        end
        if (cfg_valid && cfg_ready)
            vector_model = cfg_data;
        if (s_tvalid && s_tready)
        begin
            req.kind  = s_tuser;
            req.chan  = s_tdata[1:0];
            req.data  = s_tdata[9:2];
            req.level = s_tdata[10];
            expected_results.push_back(predict_result(req));
            requests_sent++;
        end
    end

    // result side: random back-pressure, plus one long hold-off on request
    initial
    begin : result_sink
        logic stall_served;
        stall_served = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_start && !stall_served)
            begin
                stall_served = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    function automatic request_t make_req(input logic [2:0] kind, input logic [1:0] chan,
                                          input logic [7:0] data, input logic level);
        request_t r;
        r.kind  = kind;
        r.chan  = chan;
        r.data  = data;
        r.level = level;
        return r;
    endfunction

    function automatic request_t random_request();
        request_t r;
        int       pick;
        pick    = $urandom_range(0, 99);
        r.chan  = 2'($urandom_range(0, 3));
        r.data  = 8'($urandom_range(0, 255));
        r.level = 1'($urandom_range(0, 1));
        if (pick < 10)
        begin
            r.kind = REQ_CONTROL;
            // favour the short prescale so timers actually wrap
            if ($urandom_range(0, 3) != 0)
                r.data = r.data & ~CW_PRE256;
        end
        else if (pick < 22)
        begin
            r.kind = REQ_TCONST;
            if ($urandom_range(0, 3) != 0)
                r.data = 8'($urandom_range(1, 3));
        end
        else if (pick < 52)
            r.kind = REQ_TICK;
        else if (pick < 76)
            r.kind = REQ_TRIGGER;
        else if (pick < 94)
            r.kind = REQ_ACK;
        else
            r.kind = 3'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
        return r;
    endfunction

    // returns just after the rising edge that takes the beat
    task automatic send_request(input request_t r);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.kind;
        s_tdata  <= {5'b0, r.level, r.data, r.chan};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_vector_bank(input logic [31:0] value);
        wait_for_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_directed();
        write_vector_bank(32'hA1B2_C3D4);
        send_request(make_req(REQ_ACK, 2'd0, 8'h00, 1'b0));          // nothing pending
        send_request(make_req(REQ_SPARE_FIRST, 2'd3, 8'hFF, 1'b1));
        send_request(make_req(REQ_SPARE_LAST, 2'd1, 8'h00, 1'b0));
        send_request(make_req(REQ_CONTROL, 2'd1,
                              CW_IRQ_EN | CW_COUNTER | CW_RISING | CW_RESET, 1'b0));
        send_request(make_req(REQ_TCONST, 2'd1, 8'd1, 1'b0));
        send_request(make_req(REQ_TRIGGER, 2'd1, 8'h00, 1'b1));      // rising edge, wraps
        send_request(make_req(REQ_TRIGGER, 2'd1, 8'h00, 1'b1));      // level held, no edge
        send_request(make_req(REQ_ACK, 2'd0, 8'h00, 1'b0));
        send_request(make_req(REQ_ACK, 2'd0, 8'h00, 1'b0));
        send_request(make_req(REQ_CONTROL, 2'd2, CW_COUNTER, 1'b0));
        send_request(make_req(REQ_TRIGGER, 2'd2, 8'h00, 1'b1));      // stopped: level only
        send_request(make_req(REQ_TCONST, 2'd2, 8'd0, 1'b0));        // loads 256
        send_request(make_req(REQ_TRIGGER, 2'd2, 8'h00, 1'b0));      // falling edge counts
        send_request(make_req(REQ_CONTROL, 2'd3, CW_IRQ_EN | CW_PRE256, 1'b0));
        send_request(make_req(REQ_TRIGGER, 2'd3, 8'h00, 1'b1));      // timer ignores pin
        send_request(make_req(REQ_TCONST, 2'd3, 8'd255, 1'b0));
        send_request(make_req(REQ_TICK, 2'd0, 8'h00, 1'b0));
        send_request(make_req(REQ_CONTROL, 2'd3, CW_IRQ_EN | CW_PRE256 | CW_TC_NEXT, 1'b0));
        send_request(make_req(REQ_TICK, 2'd0, 8'h00, 1'b0));
        send_request(make_req(REQ_CONTROL, 2'd0, 8'hFF, 1'b1));
        send_request(make_req(REQ_CONTROL, 2'd0, 8'h00, 1'b0));
        send_request(make_req(REQ_TCONST, 2'd0, 8'hFF, 1'b0));
        send_request(make_req(REQ_TICK, 2'd0, 8'h00, 1'b0));
        send_request(make_req(REQ_CONTROL, 2'd2, CW_RESET, 1'b0));
    endtask

    // wrap of two timers on the same tick, ack priority, and a 256 to 16 switch
    // with a large prescaler count left behind
    task automatic test_prescale_switch();
        write_vector_bank(32'h0000_0000);
        send_request(make_req(REQ_CONTROL, 2'd0, CW_IRQ_EN | CW_RESET, 1'b0));
        send_request(make_req(REQ_CONTROL, 2'd1, CW_IRQ_EN | CW_RESET, 1'b0));
        send_request(make_req(REQ_CONTROL, 2'd3, CW_RESET, 1'b0));
        send_request(make_req(REQ_TCONST, 2'd0, 8'd1, 1'b0));
        send_request(make_req(REQ_TCONST, 2'd1, 8'd1, 1'b0));
        repeat (16)
            send_request(make_req(REQ_TICK, 2'd0, 8'h00, 1'b0));
        repeat (3)
            send_request(make_req(REQ_ACK, 2'd0, 8'h00, 1'b0));
        send_request(make_req(REQ_CONTROL, 2'd0, CW_IRQ_EN | CW_PRE256, 1'b0));
        send_request(make_req(REQ_TCONST, 2'd0, 8'd2, 1'b0));
        repeat (200)
            send_request(make_req(REQ_TICK, 2'd0, 8'h00, 1'b0));
        send_request(make_req(REQ_CONTROL, 2'd0, CW_IRQ_EN, 1'b0));
        send_request(make_req(REQ_TICK, 2'd0, 8'h00, 1'b0));
        send_request(make_req(REQ_ACK, 2'd0, 8'h00, 1'b0));
    endtask

    task automatic test_random_mix(input int count, input int send_pct, input int recv_pct,
                                   input logic [31:0] vectors);
        write_vector_bank(vectors);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (count)
            send_request(random_request());
    endtask

    // receiver holds off long enough for the block to fill and stall its input
    task automatic test_backpressure();
        write_vector_bank(32'hFFFF_FFFF);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_start   = 1'b1;
        repeat (40)
            send_request(random_request());
    endtask

    initial
    begin : test_sequence
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 32;
        recv_idle_pct = 73;
        test_directed();
        test_prescale_switch();
        test_random_mix(125, 32, 73, $urandom);
        test_random_mix(125, 73, 32, $urandom);
        test_random_mix(125, 0, 0, $urandom);
        test_backpressure();

        wait_for_results();
        repeat (8) @(negedge clk);
        if (expected_results.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, expected_results.size());
            errors++;
        end

        $display("Sent %0d requests, checked %0d result beats under three back-pressure mixes.",
                 requests_sent, beats_checked);
        $display("%0d beats reported a channel wrapping, %0d acknowledges were served.",
                 zero_beats, acks_served);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
